/* hdl/fqs_pkg.sv */
package fqs_pkg;

  localparam int KEY_W = 32;
  localparam int POS_W = 5;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 48;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_SRCH = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

/* hdl/fifo_queue_with_search.sv */
// Bounded first-in first-out queue of signed 32-bit keys in a ring of DEPTH
// entries held in one synchronous memory (one write port, one registered read
// port). One item is worked at a time, and an item is taken only while the
// output register is free, so a result that waits holds back the next item.
// An enqueue, a dequeue on an empty queue and a search on an empty queue each
// load their result straight from the idle state; a dequeue that returns a
// key first reads the key memory through its registered read port and loads
// the result from the read data. A search on a non-empty queue reads one
// entry per cycle through the single read port; it halts while a match result
// waits for the output, as the final result does; each matching entry gives one
// result with its 1-based position from the front, and a search without a
// match gives one not-found result. Opcode three is taken and dropped without
// a result. Position and occupancy are reported in 5 bits.
module fifo_queue_with_search #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fqs_pkg::S_TDATA_W-1:0]   s_tdata,  // key_in[31:0]
  input  logic [1:0]                      s_tuser,  // opcode[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fqs_pkg::M_TDATA_W-1:0]   m_tdata,  // key_out[31:0], position[36:32],
                                                    // occupancy[41:37], zero[47:42]
  output logic [1:0]                      m_tuser,  // status[1:0]
  output logic                            m_tlast
);
  import fqs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [KEY_W-1:0]        mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;
  logic [KEY_W-1:0]        mem_rdata;
  logic signed [KEY_W-1:0] key_out;
  status_t                 status;
  logic [POS_W-1:0]        position;
  logic [POS_W-1:0]        occupancy;

  fqs_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fqs_engine #(
    .DEPTH(DEPTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_op         (opcode_t'(s_tuser)),
    .in_key        (s_tdata[KEY_W-1:0]),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_key       (key_out),
    .out_status    (status),
    .out_position  (position),
    .out_occupancy (occupancy),
    .out_last      (m_tlast)
  );

  assign m_tdata = {(M_TDATA_W - KEY_W - 2 * POS_W)'(0), occupancy, position, key_out};
  assign m_tuser = status;

endmodule

/* hdl/fqs_mem.sv */
module fqs_mem #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [fqs_pkg::KEY_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [fqs_pkg::KEY_W-1:0] rdata
);
  import fqs_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/fqs_engine.sv */
module fqs_engine #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fqs_pkg::opcode_t                 in_op,
  input  logic signed [fqs_pkg::KEY_W-1:0] in_key,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic [fqs_pkg::KEY_W-1:0]        mem_wdata,
  output logic                             mem_re,
  output logic [AW-1:0]                    mem_raddr,
  input  logic [fqs_pkg::KEY_W-1:0]        mem_rdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [fqs_pkg::KEY_W-1:0] out_key,
  output fqs_pkg::status_t                 out_status,
  output logic [fqs_pkg::POS_W-1:0]        out_position,
  output logic [fqs_pkg::POS_W-1:0]        out_occupancy,
  output logic                             out_last
);
  import fqs_pkg::*;

  localparam int WW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_SRCH = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [POS_W-1:0] mask5(input logic [CW-1:0] v);
    logic [WW-1:0] t;
    t = WW'(v);
    return t[POS_W-1:0];
  endfunction

  state_t           state;
  logic [AW-1:0]    head;
  logic [AW-1:0]    tail;
  logic [CW-1:0]    fill;
  logic [AW-1:0]    idx;
  logic [CW-1:0]    cnt;
  logic [KEY_W-1:0] srch_key;
  logic             pend_valid;
  logic [KEY_W-1:0] pend_key;
  logic [CW-1:0]    pend_pos;

  logic             out_free;
  logic             accept;
  logic             full;
  logic             empty;
  logic             hit;
  logic             at_end;
  logic             srch_adv;

  logic             ld;
  logic [KEY_W-1:0] ld_key;
  status_t          ld_status;
  logic [CW-1:0]    ld_pos;
  logic [CW-1:0]    ld_occ;
  logic             ld_last;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = (fill == CW'(DEPTH));
  assign empty    = (fill == '0);
  assign hit      = (mem_rdata == srch_key);
  assign at_end   = (cnt == fill - CW'(1));
  // a second match waits while the earlier one cannot leave yet
  assign srch_adv = (state == S_SRCH) && !(hit && pend_valid && !out_free);

  assign mem_we    = accept && (in_op == OP_ENQ) && !full;
  assign mem_waddr = tail;
  assign mem_wdata = in_key;
  assign mem_re    = (accept && (in_op == OP_DEQ || in_op == OP_SRCH) && !empty) ||
                     (srch_adv && !at_end);
  assign mem_raddr = (state == S_IDLE) ? head : ring_next(idx);

  always_comb begin
    ld        = 1'b0;
    ld_key    = '0;
    ld_status = ST_OK;
    ld_pos    = '0;
    ld_occ    = fill;
    ld_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ENQ: begin
              ld = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                ld_occ = fill + CW'(1);
              end
            end
            OP_DEQ: begin
              ld        = empty;
              ld_status = ST_EMPTY;
            end
            OP_SRCH: begin
              ld        = empty;
              ld_status = ST_NOT_FOUND;
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        ld     = out_free;
        ld_key = mem_rdata;
        ld_occ = fill - CW'(1);
      end
      S_SRCH: begin
        ld      = hit && pend_valid && out_free;
        ld_key  = pend_key;
        ld_pos  = pend_pos;
        ld_last = 1'b0;
      end
      S_FIN: begin
        ld = out_free;
        if (pend_valid) begin
          ld_key = pend_key;
          ld_pos = pend_pos;
        end else begin
          ld_status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ld) begin
        out_valid <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_op)
              OP_ENQ: begin
                if (!full) begin
                  tail <= ring_next(tail);
                  fill <= fill + CW'(1);
                end
              end
              OP_DEQ: begin
                if (!empty) begin
                  state <= S_DEQ;
                end
              end
              OP_SRCH: begin
                if (!empty) begin
                  state      <= S_SRCH;
                  idx        <= head;
                  cnt        <= '0;
                  srch_key   <= in_key;
                  pend_valid <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_DEQ: begin
          if (out_free) begin
            head  <= ring_next(head);
            fill  <= fill - CW'(1);
            state <= S_IDLE;
          end
        end
        S_SRCH: begin
          if (srch_adv) begin
            if (hit) begin
              pend_valid <= 1'b1;
              pend_key   <= mem_rdata;
              pend_pos   <= cnt + CW'(1);
            end
            idx <= ring_next(idx);
            cnt <= cnt + CW'(1);
            if (at_end) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_key       <= ld_key;
      out_status    <= ld_status;
      out_position  <= mask5(ld_pos);
      out_occupancy <= mask5(ld_occ);
      out_last      <= ld_last;
    end
  end

endmodule
